FILE: rtl/framed_image_upload_receiver_core_defines.svh
// Assertion macros for the framed image upload receiver.
// Included by the top level; no other dependencies.
`ifndef FRAMED_IMAGE_UPLOAD_RECEIVER_CORE_DEFINES_SVH
`define FRAMED_IMAGE_UPLOAD_RECEIVER_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define FIUR_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define FIUR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/fiur_pkg.sv
// Package for the framed image upload receiver: codes, types, reset values, CRC step.
// No dependencies.
package fiur_pkg;

  localparam int unsigned CHUNK_BYTES_DEF = 1024;

  typedef enum logic [1:0] {
    OP_ARM  = 2'd0,
    OP_BYTE = 2'd1,
    OP_TICK = 2'd2,
    OP_FAIL = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_ACK   = 3'd0,
    K_NACK  = 3'd1,
    K_ERASE = 3'd2,
    K_WRITE = 3'd3,
    K_DONE  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_START = 3'd1,
    ST_SIZE  = 3'd2,
    ST_RECV  = 3'd3,
    ST_CRC   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_START0 = 3'd1,
    PH_START1 = 3'd2,
    PH_LENGTH = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    REG_FIRST  = 3'd0,
    REG_SECOND = 3'd1,
    REG_MAXLEN = 3'd2,
    REG_BASE   = 3'd3,
    REG_TO0    = 3'd4,
    REG_TOGRP  = 3'd5,
    REG_TOCHK  = 3'd6
  } reg_idx_t;

  localparam logic [31:0] CRC_POLY = 32'h04C11DB7;
  localparam logic [24:0] MAXLEN_RST = 25'd65536;
  localparam logic [31:0] BASE_RST = 32'd134250496;
  localparam logic [13:0] TO0_RST = 14'd5000;
  localparam logic [13:0] TOGRP_RST = 14'd2000;
  localparam logic [13:0] TOCHK_RST = 14'd10000;
  localparam logic [13:0] MS_SAT = 14'h3FFF;

  // One result item as it travels through the queue.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] addr;
    logic [7:0]  data;
    status_t     status;
    logic        last;
  } result_t;

  // Up to three result slots for the results of one input item.
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
    result_t    r2;
  } bundle_t;

  // Eight CRC bit steps (MSB first, no reflection).
  function automatic logic [31:0] crc_step8(input logic [31:0] c_in);
    logic [31:0] c;
    c = c_in;
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/fiur_crc.sv
// CRC-32 unit: folds one 32-bit word eight bits per cycle.
// Depends on fiur_pkg.
module fiur_crc (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        start,
  input  logic [31:0] word,
  output logic        busy,
  output logic [31:0] crc
);
  import fiur_pkg::*;

  logic [1:0]  step;
  logic [31:0] acc;

  assign busy = (step != 2'd0);
  assign crc  = acc;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      step <= 2'd0;
      acc  <= '1;
    end else if (start) begin
      acc  <= crc_step8(acc ^ word);
      step <= 2'd1;
    end else if (busy) begin
      acc  <= crc_step8(acc);
      step <= step + 2'd1;
    end
  end

endmodule

FILE: rtl/fiur_front.sv
// Front part: takes input items, runs the transfer sequence, builds result bundles.
// Depends on fiur_pkg and fiur_crc.
module fiur_front #(
  parameter int unsigned CHUNK_BYTES = fiur_pkg::CHUNK_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [7:0]        data_byte,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              bnd_valid,
  input  logic              bnd_ready,
  output fiur_pkg::bundle_t bnd
);
  import fiur_pkg::*;

  localparam int CW = $clog2(CHUNK_BYTES + 1);

  // configuration registers
  logic [7:0]  first_start_byte, second_start_byte;
  logic [24:0] max_image_length;
  logic [31:0] slot_base_address;
  logic [13:0] first_byte_timeout_ms, group_timeout_ms, data_timeout_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_start_byte      <= '0;
      second_start_byte     <= '0;
      max_image_length      <= MAXLEN_RST;
      slot_base_address     <= BASE_RST;
      first_byte_timeout_ms <= TO0_RST;
      group_timeout_ms      <= TOGRP_RST;
      data_timeout_ms       <= TOCHK_RST;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_FIRST:  first_start_byte      <= cfg_data[7:0];
        REG_SECOND: second_start_byte     <= cfg_data[7:0];
        REG_MAXLEN: max_image_length      <= cfg_data[24:0];
        REG_BASE:   slot_base_address     <= cfg_data;
        REG_TO0:    first_byte_timeout_ms <= cfg_data[13:0];
        REG_TOGRP:  group_timeout_ms      <= cfg_data[13:0];
        REG_TOCHK:  data_timeout_ms       <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // transfer state
  phase_t      phase, phase_next;
  logic [13:0] elapsed_ms, elapsed_ms_next;
  logic [1:0]  group_index, group_index_next;
  logic [31:0] length_shift, length_shift_next;
  logic [24:0] bytes_remaining, bytes_remaining_next;
  logic [CW-1:0] chunk_bytes_left, chunk_bytes_left_next;
  logic [24:0] write_offset, write_offset_next;
  logic [31:0] word_assembly, word_assembly_next;
  logic [31:0] received_check, received_check_next;
  logic        bnd_valid_next;
  bundle_t     bnd_next;

  // CRC unit
  logic        crc_clear, crc_start, crc_busy;
  logic [31:0] crc_word, crc_value;

  fiur_crc u_crc (
    .clk(clk), .rst(rst), .clear(crc_clear), .start(crc_start),
    .word(crc_word), .busy(crc_busy), .crc(crc_value)
  );

  // accept when bundle slot free and CRC not mid-word
  assign in_ready = (!bnd_valid || bnd_ready) && !crc_busy;
  logic take;
  assign take = in_valid && in_ready;

  function automatic result_t mk(input kind_t k, input logic [31:0] a,
                                 input logic [7:0] d, input status_t s);
    result_t r;
    r.kind = k; r.addr = a; r.data = d; r.status = s; r.last = 1'b0;
    return r;
  endfunction

  always_comb begin
    logic [24:0] chunk_full;
    logic [1:0]  gi1;
    logic [31:0] wa;
    logic [13:0] el1, limit;
    logic [1:0]  n;
    result_t     rs [3];

    chunk_full = 25'(CHUNK_BYTES);
    phase_next = phase;
    elapsed_ms_next = elapsed_ms;
    group_index_next = group_index;
    length_shift_next = length_shift;
    bytes_remaining_next = bytes_remaining;
    chunk_bytes_left_next = chunk_bytes_left;
    write_offset_next = write_offset;
    word_assembly_next = word_assembly;
    received_check_next = received_check;
    crc_clear = 1'b0;
    crc_start = 1'b0;
    crc_word = word_assembly;
    gi1 = group_index + 2'd1;
    wa = word_assembly;
    el1 = (elapsed_ms == MS_SAT) ? elapsed_ms : elapsed_ms + 14'd1;
    limit = group_timeout_ms;
    n = 2'd0;
    for (int i = 0; i < 3; i++) rs[i] = mk(K_ACK, '0, '0, ST_OK);

    if (take) begin
      case (op_t'(op))
        OP_ARM: begin
          phase_next = PH_START0;
          elapsed_ms_next = '0;
          group_index_next = '0;
          length_shift_next = '0;
          bytes_remaining_next = '0;
          chunk_bytes_left_next = '0;
          write_offset_next = '0;
          word_assembly_next = '1;
          received_check_next = '0;
          crc_clear = 1'b1;
        end
        OP_BYTE: begin
          case (phase)
            PH_START0: begin
              if (data_byte != first_start_byte) begin
                rs[0] = mk(K_DONE, '0, '0, ST_START); n = 2'd1; phase_next = PH_IDLE;
              end else begin
                phase_next = PH_START1; elapsed_ms_next = '0;
              end
            end
            PH_START1: begin
              if (data_byte != second_start_byte) begin
                rs[0] = mk(K_DONE, '0, '0, ST_START); n = 2'd1; phase_next = PH_IDLE;
              end else begin
                phase_next = PH_LENGTH; elapsed_ms_next = '0;
                group_index_next = '0; length_shift_next = '0;
              end
            end
            PH_LENGTH: begin
              length_shift_next = {data_byte, length_shift[31:8]};
              group_index_next = gi1;
              if (gi1 == 2'd0) begin
                rs[0] = mk(K_ACK, '0, '0, ST_OK);
                if (length_shift_next == '0 ||
                    length_shift_next > {7'd0, max_image_length}) begin
                  rs[1] = mk(K_DONE, '0, '0, ST_SIZE); n = 2'd2; phase_next = PH_IDLE;
                end else begin
                  rs[1] = mk(K_ERASE, '0, '0, ST_OK); n = 2'd2;
                  bytes_remaining_next = length_shift_next[24:0];
                  chunk_bytes_left_next = (length_shift_next[24:0] < chunk_full) ?
                    CW'(length_shift_next[24:0]) : CW'(CHUNK_BYTES);
                  write_offset_next = '0;
                  word_assembly_next = '1;
                  crc_clear = 1'b1;
                  elapsed_ms_next = '0;
                  phase_next = PH_DATA;
                end
              end
            end
            PH_DATA: begin
              rs[0] = mk(K_WRITE, slot_base_address + {7'd0, write_offset}, data_byte,
                         ST_OK);
              n = 2'd1;
              case (group_index)
                2'd0: wa[31:24] = data_byte;
                2'd1: wa[23:16] = data_byte;
                2'd2: wa[15:8]  = data_byte;
                default: wa[7:0] = data_byte;
              endcase
              write_offset_next = write_offset + 25'd1;
              bytes_remaining_next = bytes_remaining - 25'd1;
              chunk_bytes_left_next = chunk_bytes_left - CW'(1);
              group_index_next = gi1;
              word_assembly_next = wa;
              crc_word = wa;
              // a full word, or the padded tail of a chunk, goes to the CRC
              if (gi1 == 2'd0 || chunk_bytes_left_next == '0) begin
                crc_start = 1'b1;
                word_assembly_next = '1;
                group_index_next = '0;
              end
              if (chunk_bytes_left_next == '0) begin
                rs[1] = mk(K_ACK, '0, '0, ST_OK); n = 2'd2;
                elapsed_ms_next = '0;
                if (bytes_remaining_next == '0) begin
                  phase_next = PH_CHECK;
                  received_check_next = '0;
                end else begin
                  chunk_bytes_left_next = (bytes_remaining_next < chunk_full) ?
                    CW'(bytes_remaining_next) : CW'(CHUNK_BYTES);
                end
              end
            end
            PH_CHECK: begin
              received_check_next = {data_byte, received_check[31:8]};
              group_index_next = gi1;
              if (gi1 == 2'd0) begin
                rs[0] = mk(K_ACK, '0, '0, ST_OK);
                rs[1] = mk(K_DONE, '0, '0,
                           (crc_value == received_check_next) ? ST_OK : ST_CRC);
                n = 2'd2;
                phase_next = PH_IDLE;
              end
            end
            default: ;
          endcase
        end
        OP_TICK: begin
          if (phase != PH_IDLE) begin
            elapsed_ms_next = el1;
            if (phase == PH_START0) limit = first_byte_timeout_ms;
            else if (phase == PH_DATA) limit = data_timeout_ms;
            if (el1 >= limit) begin
              phase_next = PH_IDLE;
              if (phase == PH_START0 || phase == PH_START1) begin
                rs[0] = mk(K_DONE, '0, '0, ST_START); n = 2'd1;
              end else if (phase == PH_LENGTH) begin
                rs[0] = mk(K_DONE, '0, '0, ST_SIZE); n = 2'd1;
              end else begin
                rs[0] = mk(K_NACK, '0, '0, ST_OK);
                rs[1] = mk(K_DONE, '0, '0, ST_RECV); n = 2'd2;
              end
            end
          end
        end
        default: begin
          if (phase == PH_DATA || phase == PH_CHECK) begin
            rs[0] = mk(K_DONE, '0, '0, ST_RECV); n = 2'd1; phase_next = PH_IDLE;
          end
        end
      endcase
    end

    if (n != 2'd0) rs[n - 2'd1].last = 1'b1;
    bnd_next.count = n;
    bnd_next.r0 = rs[0];
    bnd_next.r1 = rs[1];
    bnd_next.r2 = rs[2];
    bnd_valid_next = bnd_valid && !bnd_ready;
    if (take && n != 2'd0) bnd_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      elapsed_ms <= '0;
      group_index <= '0;
      length_shift <= '0;
      bytes_remaining <= '0;
      chunk_bytes_left <= '0;
      write_offset <= '0;
      word_assembly <= '1;
      received_check <= '0;
      bnd_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      elapsed_ms <= elapsed_ms_next;
      group_index <= group_index_next;
      length_shift <= length_shift_next;
      bytes_remaining <= bytes_remaining_next;
      chunk_bytes_left <= chunk_bytes_left_next;
      write_offset <= write_offset_next;
      word_assembly <= word_assembly_next;
      received_check <= received_check_next;
      bnd_valid <= bnd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) bnd <= bnd_next;
  end

endmodule

FILE: rtl/fiur_back.sv
// Back part: two-entry bundle queue and serializer onto the result stream.
// Depends on fiur_pkg.
module fiur_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              bnd_valid,
  output logic              bnd_ready,
  input  fiur_pkg::bundle_t bnd,
  output logic              res_valid,
  input  logic              res_ready,
  output fiur_pkg::result_t res
);
  import fiur_pkg::*;

  bundle_t    q [2];
  logic       wp, rp;
  logic [1:0] fill;
  logic [1:0] idx;
  logic       pop, push;

  assign bnd_ready = (fill != 2'd2);
  assign push = bnd_valid && bnd_ready;
  assign res_valid = (fill != 2'd0);

  // pick the current result of the head bundle
  always_comb begin
    case (idx)
      2'd0:    res = q[rp].r0;
      2'd1:    res = q[rp].r1;
      default: res = q[rp].r2;
    endcase
  end

  assign pop = res_valid && res_ready && res.last;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= bnd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; fill <= '0; idx <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) begin
        rp <= ~rp; idx <= '0;
      end else if (res_valid && res_ready) begin
        idx <= idx + 2'd1;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/framed_image_upload_receiver_core.sv
// Top level of the framed image upload receiver: ports, front and back parts, checks.
// Depends on fiur_pkg, fiur_front, fiur_back and the defines header.
//
// Takes arm, serial byte, millisecond tick and flash failure items and emits ACK, NACK,
// erase, flash byte write and finished results, up to two per item. An item is taken
// in any cycle where the result slot is free and the CRC unit is idle. A data byte that
// completes a word or ends a chunk starts the CRC unit, which folds eight bits a cycle,
// so the input is held off while the CRC unit is busy after that byte. Each result
// bundle is held in a two-entry queue and sent one result a beat; a stalled result
// stream backs up into the input once both queue entries and the result slot are full.
`include "framed_image_upload_receiver_core_defines.svh"
module framed_image_upload_receiver_core #(
  parameter int unsigned CHUNK_BYTES = fiur_pkg::CHUNK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] flash_address, [39:32] flash_data, [42:40] status
  output logic [2:0]  m_axis_tuser,   // [2:0] result_kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import fiur_pkg::*;

  logic    bnd_valid, bnd_ready;
  bundle_t bnd;
  result_t res;

  assign cfg_ready = 1'b1;

  fiur_front #(.CHUNK_BYTES(CHUNK_BYTES)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .op(s_axis_tuser), .data_byte(s_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .bnd_valid(bnd_valid), .bnd_ready(bnd_ready), .bnd(bnd)
  );

  fiur_back u_back (
    .clk(clk), .rst(rst),
    .bnd_valid(bnd_valid), .bnd_ready(bnd_ready), .bnd(bnd),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
  );

  assign m_axis_tdata = {5'd0, res.status, res.data, res.addr};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

  // checks
  `FIUR_ASSERT(a_bnd_nonempty, bnd_valid, bnd.count != 2'd0, "empty bundle queued")
  `FIUR_ASSERT(a_write_status, m_axis_tvalid && m_axis_tuser == K_WRITE,
    m_axis_tdata[42:40] == ST_OK, "flash write with status")
  `FIUR_ASSERT_NEXT(a_arm_silent,
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_ARM && !bnd_valid,
    !bnd_valid, "arm produced a result")

endmodule
